FILE: sv/ifds_pkg.sv
package ifds_pkg;

  // Frame layout
  localparam logic [7:0] NEWLINE_BYTE = 8'd10;
  localparam int unsigned FRAME_BODY = 11;
  localparam int unsigned NUM_AXES = 5;
  localparam logic [3:0] COUNT_POS = 4'd10;
  localparam logic [3:0] TERM_POS = 4'd11;

  // Result status codes
  localparam logic [1:0] STATUS_OK = 2'd0;
  localparam logic [1:0] STATUS_SYNC = 2'd1;
  localparam logic [1:0] STATUS_ZERO = 2'd2;

  // Axis order inside a frame
  localparam logic [2:0] AXIS_GYRO_X = 3'd0;
  localparam logic [2:0] AXIS_GYRO_Z = 3'd1;
  localparam logic [2:0] AXIS_ACC_X = 3'd2;
  localparam logic [2:0] AXIS_ACC_Y = 3'd3;
  localparam logic [2:0] AXIS_ACC_Z = 3'd4;

  // Configuration register indexes
  localparam logic [2:0] CFG_GYRO_OFFSET = 3'd0;
  localparam logic [2:0] CFG_GYRO_SCALE = 3'd1;
  localparam logic [2:0] CFG_ACC_XY_OFFSET = 3'd2;
  localparam logic [2:0] CFG_ACC_Z_OFFSET = 3'd3;
  localparam logic [2:0] CFG_ACC_SCALE = 3'd4;

  // Configuration reset values
  localparam logic [23:0] RST_GYRO_OFFSET = 24'd97690;
  localparam logic [23:0] RST_GYRO_SCALE = 24'd94287;
  localparam logic [23:0] RST_ACC_XY_OFFSET = 24'd131072;
  localparam logic [23:0] RST_ACC_Z_OFFSET = 24'd194622;
  localparam logic [23:0] RST_ACC_SCALE = 24'd663027;

  // Frame queue depth between deframer and scaler
  localparam int unsigned QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [23:0] gyro_offset;
    logic [23:0] gyro_scale;
    logic [23:0] acc_xy_offset;
    logic [23:0] acc_z_offset;
    logic [23:0] acc_scale;
  } cfg_t;

  // One deframed frame, ready for scaling
  typedef struct packed {
    logic [1:0] status;
    logic [7:0] count;
    logic [NUM_AXES-1:0][15:0] sums;
  } job_t;

  // Queue status seen by both sides
  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

endpackage

FILE: sv/ifds_front.sv
module ifds_front
  import ifds_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  rx_byte_i,
  input  queue_stat_t q_stat_i,
  output logic        push_o,
  output job_t        push_job_o
);

  logic       hunting_q, hunting_d;
  logic [3:0] idx_q, idx_d;
  logic [7:0] store_q [FRAME_BODY];
  logic       accept;
  logic       at_term;

  assign in_stall_o = q_stat_i.full;
  assign accept = in_valid_i && !in_stall_o;
  assign at_term = (idx_q >= TERM_POS);
  assign push_o = accept && !hunting_q && at_term;

  // Classify the frame at its terminator
  always_comb begin
    push_job_o.count = store_q[COUNT_POS];
    for (int k = 0; k < NUM_AXES; k++) begin
      push_job_o.sums[k] = {store_q[2*k], store_q[2*k+1]};
    end
    if (rx_byte_i != NEWLINE_BYTE) begin
      push_job_o.status = STATUS_SYNC;
    end else if (store_q[COUNT_POS] == 8'd0) begin
      push_job_o.status = STATUS_ZERO;
    end else begin
      push_job_o.status = STATUS_OK;
    end
  end

  // Hunt for newline, then walk through the frame
  always_comb begin
    hunting_d = hunting_q;
    idx_d = idx_q;
    if (accept) begin
      if (hunting_q) begin
        if (rx_byte_i == NEWLINE_BYTE) begin
          hunting_d = 1'b0;
          idx_d = 4'd0;
        end
      end else if (!at_term) begin
        idx_d = idx_q + 4'd1;
      end else begin
        idx_d = 4'd0;
        if (rx_byte_i != NEWLINE_BYTE) begin
          hunting_d = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hunting_q <= 1'b1;
      idx_q <= 4'd0;
    end else begin
      hunting_q <= hunting_d;
      idx_q <= idx_d;
    end
  end

  // Capture frame body beats
  always_ff @(posedge clk_i) begin
    if (accept && !hunting_q && !at_term) begin
      store_q[idx_q] <= rx_byte_i;
    end
  end

endmodule

FILE: sv/ifds_queue.sv
module ifds_queue
  import ifds_pkg::*;
#(
  parameter int unsigned Depth = QUEUE_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  job_t        push_job_i,
  input  logic        pop_i,
  output job_t        pop_job_o,
  output queue_stat_t stat_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  job_t           slot_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign stat_o.full = (cnt_q == FullCnt);
  assign stat_o.empty = (cnt_q == '0);
  assign do_push = push_i && !stat_o.full;
  assign do_pop = pop_i && !stat_o.empty;
  assign pop_job_o = slot_q[rd_q];

  // Advance pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0;
      rd_q <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == LastPtr) ? '0 : wr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_q <= (rd_q == LastPtr) ? '0 : rd_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_q] <= push_job_i;
    end
  end

endmodule

FILE: sv/ifds_back.sv
module ifds_back
  import ifds_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cfg_t        cfg_i,
  input  queue_stat_t q_stat_i,
  input  job_t        pop_job_i,
  output logic        pop_o,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic [31:0] gyro_x_rate_o,
  output logic [31:0] gyro_z_rate_o,
  output logic [31:0] accel_x_o,
  output logic [31:0] accel_y_o,
  output logic [31:0] accel_z_o,
  output logic [7:0]  sample_count_o
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_DIV  = 5'b00010,
    S_MUL  = 5'b00100,
    S_SAT  = 5'b01000,
    S_DONE = 5'b10000
  } state_e;

  localparam logic signed [49:0] RoundBias = 50'sd32768;

  state_e                    state_q, state_d;
  job_t                      job_q;
  logic [2:0]                lane_q;
  logic [3:0]                bit_q;
  logic [7:0]                rem_q;
  logic [15:0]               dvd_q;
  logic [15:0]               quo_q;
  logic signed [49:0]        prod_q;
  logic [NUM_AXES-1:0][31:0] res_q;
  logic                      out_valid_q;

  logic [8:0]         rem_sh;
  logic               ge;
  logic [8:0]         rem_sub;
  logic [23:0]        off_sel;
  logic [23:0]        scale_sel;
  logic signed [24:0] diff;
  logic signed [49:0] prod_d;
  logic signed [49:0] biased;
  logic [33:0]        shifted;
  logic [31:0]        sat;
  logic [2:0]         lane_nx;
  logic               out_free;
  logic               load_out;

  // One quotient bit per cycle
  assign rem_sh = {rem_q, dvd_q[15]};
  assign ge = (rem_sh >= {1'b0, job_q.count});
  assign rem_sub = rem_sh - {1'b0, job_q.count};

  // Pick zero level and scale for the current axis
  always_comb begin
    priority if (lane_q == AXIS_GYRO_X || lane_q == AXIS_GYRO_Z) begin
      off_sel = cfg_i.gyro_offset;
      scale_sel = cfg_i.gyro_scale;
    end else if (lane_q == AXIS_ACC_X || lane_q == AXIS_ACC_Y) begin
      off_sel = cfg_i.acc_xy_offset;
      scale_sel = cfg_i.acc_scale;
    end else begin
      off_sel = cfg_i.acc_z_offset;
      scale_sel = cfg_i.acc_scale;
    end
  end

  assign diff = $signed({1'b0, quo_q, 8'd0}) - $signed({1'b0, off_sel});
  assign prod_d = diff * $signed({1'b0, scale_sel});

  // Round half up to Q15.16, then saturate to 32 bits
  assign biased = prod_q + RoundBias;
  assign shifted = biased[49:16];
  always_comb begin
    if (shifted[33:31] == 3'b000 || shifted[33:31] == 3'b111) begin
      sat = shifted[31:0];
    end else if (shifted[33]) begin
      sat = 32'h8000_0000;
    end else begin
      sat = 32'h7fff_ffff;
    end
  end

  assign lane_nx = (lane_q == AXIS_ACC_Z) ? AXIS_GYRO_X : lane_q + 3'd1;
  assign out_free = !out_valid_q || !out_stall_i;
  assign load_out = (state_q == S_DONE) && out_free;
  assign pop_o = (state_q == S_IDLE) && !q_stat_i.empty;

  // Sequence divide, multiply and saturate over the five axes; frames with a bad status go straight to done
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (!q_stat_i.empty) begin
          state_d = (pop_job_i.status == STATUS_OK) ? S_DIV : S_DONE;
        end
      end
      S_DIV: begin
        if (bit_q == 4'd15) begin
          state_d = S_MUL;
        end
      end
      S_MUL: begin
        state_d = S_SAT;
      end
      S_SAT: begin
        state_d = (lane_q == AXIS_ACC_Z) ? S_DONE : S_DIV;
      end
      S_DONE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        job_q <= pop_job_i;
        lane_q <= AXIS_GYRO_X;
        bit_q <= 4'd0;
        rem_q <= 8'd0;
        dvd_q <= pop_job_i.sums[AXIS_GYRO_X];
        res_q <= '0;
      end
      S_DIV: begin
        rem_q <= ge ? rem_sub[7:0] : rem_sh[7:0];
        dvd_q <= {dvd_q[14:0], 1'b0};
        quo_q <= {quo_q[14:0], ge};
        bit_q <= bit_q + 4'd1;
      end
      S_MUL: begin
        prod_q <= prod_d;
      end
      S_SAT: begin
        res_q[lane_q] <= sat;
        lane_q <= lane_nx;
        bit_q <= 4'd0;
        rem_q <= 8'd0;
        dvd_q <= job_q.sums[lane_nx];
      end
      S_DONE: begin
      end
      default: begin
      end
    endcase
  end

  // Hold the result beat until taken
  always_ff @(posedge clk_i) begin
    if (load_out) begin
      status_o <= job_q.status;
      sample_count_o <= job_q.count;
      gyro_x_rate_o <= res_q[AXIS_GYRO_X];
      gyro_z_rate_o <= res_q[AXIS_GYRO_Z];
      accel_x_o <= res_q[AXIS_ACC_X];
      accel_y_o <= res_q[AXIS_ACC_Y];
      accel_z_o <= res_q[AXIS_ACC_Z];
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

FILE: sv/imu_frame_deframe_and_scale.sv
// IMU serial deframer and scaler. Takes one received byte per input beat,
// drops bytes until a newline, then collects 12-byte frames: five big-endian
// 16-bit sums (gyro x, gyro z, accel x, accel y, accel z), a sample count and
// a newline terminator. At each terminator one result beat is produced:
// status 0 with the five averages converted to signed Q15.16 (rounded,
// saturated), status 1 when the terminator is wrong (the block then hunts
// again), or status 2 when the count is zero; the rates are zero unless the
// status is 0. The deframer takes one byte per cycle unless the queue is
// full. The scaler handles one frame at a time: for each of the five axes
// it runs a restoring divider, then a multiply and a saturate step. A
// two-frame queue sits between them, and the output register holds a
// result while the next frame is scaled. Configuration writes are applied
// at once and must be made only while the block is idle.
module imu_frame_deframe_and_scale
  import ifds_pkg::*;
#(
  parameter int unsigned QueueDepth = QUEUE_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [23:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic [31:0] gyro_x_rate_o,
  output logic [31:0] gyro_z_rate_o,
  output logic [31:0] accel_x_o,
  output logic [31:0] accel_y_o,
  output logic [31:0] accel_z_o,
  output logic [7:0]  sample_count_o
);

  cfg_t        cfg_q;
  queue_stat_t q_stat;
  logic        push;
  job_t        push_job;
  logic        pop;
  job_t        pop_job;

  // Configuration registers; writes to unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gyro_offset <= RST_GYRO_OFFSET;
      cfg_q.gyro_scale <= RST_GYRO_SCALE;
      cfg_q.acc_xy_offset <= RST_ACC_XY_OFFSET;
      cfg_q.acc_z_offset <= RST_ACC_Z_OFFSET;
      cfg_q.acc_scale <= RST_ACC_SCALE;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_GYRO_OFFSET:   cfg_q.gyro_offset <= cfg_wdata_i;
        CFG_GYRO_SCALE:    cfg_q.gyro_scale <= cfg_wdata_i;
        CFG_ACC_XY_OFFSET: cfg_q.acc_xy_offset <= cfg_wdata_i;
        CFG_ACC_Z_OFFSET:  cfg_q.acc_z_offset <= cfg_wdata_i;
        CFG_ACC_SCALE:     cfg_q.acc_scale <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  ifds_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .rx_byte_i  (rx_byte_i),
    .q_stat_i   (q_stat),
    .push_o     (push),
    .push_job_o (push_job)
  );

  ifds_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_job_i (push_job),
    .pop_i      (pop),
    .pop_job_o  (pop_job),
    .stat_o     (q_stat)
  );

  ifds_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .q_stat_i       (q_stat),
    .pop_job_i      (pop_job),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .status_o       (status_o),
    .gyro_x_rate_o  (gyro_x_rate_o),
    .gyro_z_rate_o  (gyro_z_rate_o),
    .accel_x_o      (accel_x_o),
    .accel_y_o      (accel_y_o),
    .accel_z_o      (accel_z_o),
    .sample_count_o (sample_count_o)
  );

endmodule
